/* rtl/itsa_pkg.sv */
`default_nettype none

package itsa_pkg;

    // Pool size and derived widths
    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // Field widths
    localparam int CMD_W      = 2;
    localparam int OWNER_W    = 15;
    localparam int COOKIE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int BYTES_W    = 21;
    localparam int ADDR_W     = 64;
    localparam int PAGES_W    = 32;
    localparam int LIMIT_W    = 32;
    localparam int SPARE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Region size is always a power of two; it is carried as its log2
    localparam int LOG_W = 5;

    localparam logic [PAGES_W-1:0] PAGES_64K  = 32'h0000_1000;
    localparam logic [PAGES_W-1:0] PAGES_256K = 32'h0000_4000;
    localparam logic [PAGES_W-1:0] PAGES_512K = 32'h0001_0000;

    localparam logic [LIMIT_W-1:0] SZ_FLOOR = 32'h0000_2000;
    localparam logic [LIMIT_W-1:0] SZ_CEIL  = 32'h0010_0000;

    localparam logic [LOG_W-1:0] LOG_64K   = 5'd16;
    localparam logic [LOG_W-1:0] LOG_256K  = 5'd18;
    localparam logic [LOG_W-1:0] LOG_512K  = 5'd19;
    localparam logic [LOG_W-1:0] LOG_1M    = 5'd20;
    localparam int               LOG_FLOOR = 13;
    localparam int               LOG_CEIL  = 20;

    // Reset values of the configuration registers
    localparam logic [LIMIT_W-1:0] SIZE_MIN_RST = 32'h0000_2000;
    localparam logic [LIMIT_W-1:0] SIZE_MAX_RST = 32'h0010_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 2'd0,
        STS_NO_SLOT  = 2'd1,
        STS_NOT_USED = 2'd2,
        STS_RANGE    = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEM_PAGES   = 3'd0,
        REG_SIZE_MIN    = 3'd1,
        REG_SIZE_MAX    = 3'd2,
        REG_SPARE_SLOTS = 3'd3,
        REG_BOOT_IOMMUS = 3'd4,
        REG_BASE_ADDR   = 3'd5
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_CHECK,
        ST_ADDR,
        ST_DONE
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;   // capture the request
        logic prep;   // register size and slot count, set slot index
        logic scan;   // alloc: look at one slot
        logic check;  // free / query: look up the cookie's slot
        logic addr;   // form the region address
        logic emit;   // move the result into the output register
    } t_ctl;

    // Datapath -> controller
    typedef struct packed {
        logic is_alloc;
        logic scan_end;
        logic slot_free;
        logic cookie_ok;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/itsa_if.sv */
`default_nettype none

interface itsa_req_if import itsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [OWNER_W-1:0]  owner_id;
    logic [COOKIE_W-1:0] cookie;

    modport source (output valid, cmd, owner_id, cookie, input ready);
    modport sink   (input valid, cmd, owner_id, cookie, output ready);
endinterface

interface itsa_rsp_if import itsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COOKIE_W-1:0] slot;
    logic [BYTES_W-1:0]  region_bytes;
    logic [ADDR_W-1:0]   region_address;
    logic [OWNER_W-1:0]  slot_owner;

    modport source (output valid, status, slot, region_bytes, region_address, slot_owner,
                    input ready);
    modport sink   (input valid, status, slot, region_bytes, region_address, slot_owner,
                    output ready);
endinterface

interface itsa_cfg_if import itsa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/iommu_table_slot_allocator_top.sv */
// IOMMU translation-table slot allocator.
// Hands out equal-sized table regions laid out back to back from a base.
// Channels (valid/ready, a request moves when both are high):
//   i_cfg : register writes (index, data); always ready. Write only while
//           no request is in flight and the response channel is drained.
//   i_req : cmd (alloc / free / query), owner_id, cookie (slot number).
//   o_rsp : status, slot, region_bytes, region_address, slot_owner;
//           exactly one response per request, in order.
// Timing: one request at a time, driven by a small sequencer.
//   free / query : after accept, PREP, CHECK, ADDR, then DONE, which
//                  loads the response; no ADDR for an out-of-range cookie.
//   alloc        : PREP, then SCAN until a free slot is granted or all n
//                  slots were tried, ADDR when a slot is granted, then DONE;
//                  the first-fit search reads one slot per cycle.
//   The next request is taken the cycle after the response is loaded.
// Response register: a finished response waits there; the block takes the
// next request meanwhile and stalls only when its own result is ready and
// the register is still full.
// Reset (i_rst_n low, synchronous): every slot free, registers at defaults,
// no response pending.

`default_nettype none

module iommu_table_slot_allocator_top import itsa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    itsa_cfg_if.sink     i_cfg,
    itsa_req_if.sink     i_req,
    itsa_rsp_if.source   o_rsp
);

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_req_ready;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = w_req_ready;

    itsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    itsa_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_cmd            (i_req.cmd),
        .i_owner_id       (i_req.owner_id),
        .i_cookie         (i_req.cookie),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_slot           (o_rsp.slot),
        .o_region_bytes   (o_rsp.region_bytes),
        .o_region_address (o_rsp.region_address),
        .o_slot_owner     (o_rsp.slot_owner),
        .i_ctl            (w_ctl),
        .o_sts            (w_sts)
    );

endmodule

`default_nettype wire

/* rtl/itsa_ctrl.sv */
`default_nettype none

module itsa_ctrl import itsa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_sts i_sts,
    output t_ctl      o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_ctl       = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                o_ctl.prep = 1'b1;
                n_state    = i_sts.is_alloc ? ST_SCAN : ST_CHECK;
            end
            ST_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = ST_DONE;
                end else if (i_sts.slot_free) begin
                    n_state = ST_ADDR;
                end
            end
            ST_CHECK: begin
                o_ctl.check = 1'b1;
                n_state     = i_sts.cookie_ok ? ST_ADDR : ST_DONE;
            end
            ST_ADDR: begin
                o_ctl.addr = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/itsa_datapath.sv */
`default_nettype none

module itsa_datapath import itsa_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // request payload
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [OWNER_W-1:0]    i_owner_id,
    input  wire logic [COOKIE_W-1:0]   i_cookie,
    // response register
    input  wire logic                  i_rsp_ready,
    output logic                       o_rsp_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic [COOKIE_W-1:0]        o_slot,
    output logic [BYTES_W-1:0]         o_region_bytes,
    output logic [ADDR_W-1:0]          o_region_address,
    output logic [OWNER_W-1:0]         o_slot_owner,
    // controller
    input  wire t_ctl                  i_ctl,
    output t_sts                       o_sts
);

    // highest set bit in the region-size range; input is known to be in
    // [SZ_FLOOR, SZ_CEIL] when used
    function automatic logic [LOG_W-1:0] msb_log(input logic [LIMIT_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = LOG_W'(LOG_FLOOR);
        for (int b = LOG_FLOOR; b <= LOG_CEIL; b++) begin
            if (v[b]) begin
                r = LOG_W'(b);
            end
        end
        return r;
    endfunction

    // configuration
    logic [PAGES_W-1:0] r_mem_pages;
    logic [LIMIT_W-1:0] r_size_min;
    logic [LIMIT_W-1:0] r_size_max;
    logic [SPARE_W-1:0] r_spare_slots;
    logic [SPARE_W-1:0] r_boot_iommus;
    logic [ADDR_W-1:0]  r_base_address;

    // request and work registers
    logic [CMD_W-1:0]    r_cmd;
    logic [OWNER_W-1:0]  r_owner;
    logic [COOKIE_W-1:0] r_cookie;
    logic [LOG_W-1:0]    r_shamt;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_idx;
    logic [STATUS_W-1:0] r_status;
    logic [COOKIE_W-1:0] r_slot;
    logic [OWNER_W-1:0]  r_own_out;
    logic [ADDR_W-1:0]   r_addr;

    // slot table: in-use bits are reset, owners are written before use
    logic [MAX_SLOTS-1:0] r_used;
    logic [OWNER_W-1:0]   r_owners [MAX_SLOTS];

    // output register
    logic                r_rsp_valid;
    logic [STATUS_W-1:0] r_rsp_status;
    logic [COOKIE_W-1:0] r_rsp_slot;
    logic [BYTES_W-1:0]  r_rsp_bytes;
    logic [ADDR_W-1:0]   r_rsp_addr;
    logic [OWNER_W-1:0]  r_rsp_owner;

    logic [LOG_W-1:0]   n_shamt;
    logic [CNT_W-1:0]   n_cnt;
    logic [LIMIT_W-1:0] w_lo;
    logic [LIMIT_W-1:0] w_hi;
    logic [LOG_W-1:0]   w_lo_log;
    logic [LOG_W-1:0]   w_hi_log;
    logic [SPARE_W-1:0] w_want;
    logic [SLOT_W-1:0]  w_sel;
    logic               w_entry_used;
    logic               w_scan_end;
    logic               w_cookie_ok;

    // region size (as log2) and slot count
    always_comb begin
        if (r_mem_pages <= PAGES_64K) begin
            n_shamt = LOG_64K;
        end else if (r_mem_pages <= PAGES_256K) begin
            n_shamt = LOG_256K;
        end else if (r_mem_pages <= PAGES_512K) begin
            n_shamt = LOG_512K;
        end else begin
            n_shamt = LOG_1M;
        end
        w_lo     = (r_size_min > SZ_FLOOR) ? r_size_min : SZ_FLOOR;
        w_hi     = (r_size_max < SZ_CEIL) ? r_size_max : SZ_CEIL;
        w_lo_log = msb_log(w_lo);
        w_hi_log = msb_log(w_hi);
        if (w_lo <= w_hi) begin
            if (n_shamt > w_hi_log) begin
                n_shamt = w_hi_log;
            end
            if (n_shamt < w_lo_log) begin
                n_shamt = w_lo_log;
            end
        end
        w_want = (r_spare_slots > r_boot_iommus) ? r_spare_slots : r_boot_iommus;
        n_cnt  = (w_want > SPARE_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : w_want[CNT_W-1:0];
    end

    assign w_sel        = r_idx[SLOT_W-1:0];
    assign w_entry_used = r_used[w_sel];
    assign w_scan_end   = (r_idx == r_cnt);
    assign w_cookie_ok  = (r_cookie < COOKIE_W'(r_cnt));

    assign o_sts.is_alloc  = (r_cmd == CMD_ALLOC);
    assign o_sts.scan_end  = w_scan_end;
    assign o_sts.slot_free = !w_entry_used;
    assign o_sts.cookie_ok = w_cookie_ok;
    assign o_sts.out_free  = !r_rsp_valid || i_rsp_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_pages    <= '0;
            r_size_min     <= SIZE_MIN_RST;
            r_size_max     <= SIZE_MAX_RST;
            r_spare_slots  <= '0;
            r_boot_iommus  <= '0;
            r_base_address <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_MEM_PAGES:   r_mem_pages    <= i_cfg_data[PAGES_W-1:0];
                REG_SIZE_MIN:    r_size_min     <= i_cfg_data[LIMIT_W-1:0];
                REG_SIZE_MAX:    r_size_max     <= i_cfg_data[LIMIT_W-1:0];
                REG_SPARE_SLOTS: r_spare_slots  <= i_cfg_data[SPARE_W-1:0];
                REG_BOOT_IOMMUS: r_boot_iommus  <= i_cfg_data[SPARE_W-1:0];
                REG_BASE_ADDR:   r_base_address <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // in-use bits and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_ctl.scan && !w_scan_end && !w_entry_used) begin
                r_used[w_sel] <= 1'b1;
            end else if (i_ctl.check && w_cookie_ok && (r_cmd == CMD_FREE)) begin
                r_used[w_sel] <= 1'b0;
            end
            if (i_ctl.emit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_owner  <= i_owner_id;
            r_cookie <= i_cookie;
        end
        if (i_ctl.prep) begin
            r_shamt <= n_shamt;
            r_cnt   <= n_cnt;
            r_idx   <= (r_cmd == CMD_ALLOC) ? '0 : r_cookie[CNT_W-1:0];
        end
        if (i_ctl.scan) begin
            if (w_scan_end) begin
                r_status  <= STS_NO_SLOT;
                r_slot    <= '0;
                r_own_out <= '0;
                r_addr    <= '0;
            end else if (!w_entry_used) begin
                r_owners[w_sel] <= r_owner;
                r_status        <= STS_OK;
                r_slot          <= COOKIE_W'(r_idx);
                r_own_out       <= r_owner;
            end else begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
        if (i_ctl.check) begin
            r_slot <= r_cookie;
            if (!w_cookie_ok) begin
                r_status  <= STS_RANGE;
                r_own_out <= '0;
                r_addr    <= '0;
            end else if (w_entry_used) begin
                r_status  <= STS_OK;
                r_own_out <= r_owners[w_sel];
            end else begin
                r_status  <= STS_NOT_USED;
                r_own_out <= '0;
            end
        end
        if (i_ctl.addr) begin
            r_addr <= r_base_address + (ADDR_W'(w_sel) << r_shamt);
        end
        if (i_ctl.emit) begin
            r_rsp_status <= r_status;
            r_rsp_slot   <= r_slot;
            r_rsp_bytes  <= BYTES_W'(1) << r_shamt;
            r_rsp_addr   <= r_addr;
            r_rsp_owner  <= r_own_out;
        end
    end

    assign o_rsp_valid      = r_rsp_valid;
    assign o_status         = r_rsp_status;
    assign o_slot           = r_rsp_slot;
    assign o_region_bytes   = r_rsp_bytes;
    assign o_region_address = r_rsp_addr;
    assign o_slot_owner     = r_rsp_owner;

endmodule

`default_nettype wire
